// File: sv/sha256_pkg.sv
// SHA-256 stream hasher: shared types, constants and round functions.
// Depends on nothing; imported by every module of the block.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_core_ctl;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

endpackage

// File: sv/sha256_core.sv
// SHA-256 compression: one round per cycle on a shared round unit.
// Takes a 16-word block through a shift window. Depends on sha256_pkg.
module sha256_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_init,
    input  logic [31:0]           i_block_word,
    input  logic                  i_word_valid,
    output sha256_pkg::t_core_ctl o_ctl,
    input  logic [2:0]            i_rd_index,
    output logic [31:0]           o_rd_word
);
    import sha256_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [6:0]  r_round;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_t;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        if (r_round < 7'd16) begin
            w_t = r_w[0];
        end else begin
            w_t = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];
        end
        t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
            + ROUND_K[r_round[5:0]] + w_t;
        t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
            for (int k = 0; k < 8; k++) r_h[k] <= INIT_HASH[k];
        end else begin
            r_done <= 1'b0;
            if (i_init) begin
                for (int k = 0; k < 8; k++) r_h[k] <= INIT_HASH[k];
            end
            if (i_word_valid) begin
                for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                r_w[15] <= i_block_word;
            end
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
            end else if (r_busy) begin
                if (r_round == 7'd64) begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                    r_w[15] <= w_t;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 7'd1;
                end
            end
        end
    end

    assign o_ctl     = '{start: i_start, busy: r_busy, done: r_done};
    assign o_rd_word = r_h[i_rd_index];

endmodule

// File: sv/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte packing, padding sequencer, digest output.
// Depends on sha256_pkg and sha256_core.
//
// One byte is taken per beat and packed into 32-bit words that shift straight into
// the round unit's window. Each full 64-byte block is compressed in the single
// shared round unit (64 rounds and a fold into the chaining words), during which
// input is refused with o_stall high. At end of message the words still missing
// from the block are fed one a cycle (up to 16 words a block); ST_LOAD launches the
// compression and ST_FOLD waits for it, for each of the one or two padding blocks;
// then the eight digest words leave one per accepted output beat, H0 first.
module sha256_stream_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sha256_pkg::t_in_beat  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sha256_pkg::t_out_beat o_data
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_fill;
    logic [60:0] r_total;
    logic [31:0] r_word;
    logic        r_end;
    logic        r_second;
    logic [3:0]  r_pad_idx;
    logic [2:0]  r_out_idx;

    t_core_ctl   core_ctl;
    logic        core_start;
    logic        core_init;
    logic        word_valid;
    logic [31:0] word_in;
    logic [31:0] rd_word;
    logic        accept;
    logic        extra_block;
    logic [63:0] bit_len;
    logic [3:0]  pad_word;
    logic [1:0]  pad_byte;
    logic [5:0]  pos;
    logic [31:0] pad_val;
    logic [31:0] part_word;
    logic [5:0]  fill_after;

    assign accept  = i_valid && !o_stall;
    assign bit_len = {r_total, 3'b000};
    assign extra_block = (r_fill > 6'd55);
    assign fill_after  = r_fill + {5'd0, i_data.byte_present};

    // Padding word builder over the partial word still in r_word.
    always_comb begin
        pad_word  = r_fill[5:2];
        pad_byte  = r_fill[1:0];
        part_word = r_word << {3'd4 - {1'b0, pad_byte}, 3'b000};
        pad_val   = '0;
        for (int b = 0; b < 4; b++) begin
            pos = {r_pad_idx, 2'(b)};
            if (!r_second && r_pad_idx < pad_word) begin
                pad_val[31-8*b -: 8] = 8'h00;
            end else if (!r_second && r_pad_idx == pad_word && 2'(b) < pad_byte) begin
                pad_val[31-8*b -: 8] = part_word[31-8*b -: 8];
            end else if (!r_second && pos == r_fill) begin
                pad_val[31-8*b -: 8] = PAD_BYTE;
            end else begin
                pad_val[31-8*b -: 8] = 8'h00;
            end
        end
        if (!r_second && r_pad_idx < pad_word) pad_val = 32'h0;
        if (!(extra_block && !r_second)) begin
            if (r_pad_idx == 4'd14) pad_val = bit_len[63:32];
            if (r_pad_idx == 4'd15) pad_val = bit_len[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_data.byte_present && r_fill == 6'd63) n_state = ST_ROUND;
                    else if (i_data.end_of_message) n_state = ST_PAD;
                end
            end
            ST_LOAD:  n_state = ST_FOLD;
            ST_ROUND: if (core_ctl.done) n_state = r_end ? ST_PAD : ST_IDLE;
            ST_PAD: begin
                if (r_pad_idx == 4'd15) n_state = ST_LOAD;
            end
            ST_FOLD: if (core_ctl.done) n_state = (extra_block && !r_second) ? ST_PAD : ST_EMIT;
            ST_EMIT: if (!i_stall && r_out_idx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall    = (r_state != ST_IDLE);
        o_valid    = (r_state == ST_EMIT);
        word_valid = 1'b0;
        word_in    = pad_val;
        core_start = 1'b0;
        core_init  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_data.byte_present && r_fill[1:0] == 2'd3) begin
                    word_valid = 1'b1;
                    word_in    = {r_word[23:0], i_data.data_byte};
                end
                core_start = accept && i_data.byte_present && r_fill == 6'd63;
            end
            ST_PAD:  word_valid = 1'b1;
            ST_LOAD: core_start = 1'b1;
            ST_EMIT: core_init = !i_stall && r_out_idx == 3'd7;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_total   <= '0;
            r_end     <= 1'b0;
            r_second  <= 1'b0;
            r_pad_idx <= '0;
            r_out_idx <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_end <= i_data.end_of_message;
                        if (i_data.byte_present) begin
                            r_word  <= {r_word[23:0], i_data.data_byte};
                            r_fill  <= r_fill + 6'd1;
                            r_total <= r_total + 61'd1;
                        end
                        r_pad_idx <= fill_after[5:2];
                        r_second  <= 1'b0;
                    end
                end
                ST_PAD: r_pad_idx <= r_pad_idx + 4'd1;
                ST_ROUND: begin
                    if (core_ctl.done) r_pad_idx <= '0;
                end
                ST_FOLD: begin
                    if (core_ctl.done) begin
                        r_pad_idx <= '0;
                        if (extra_block && !r_second) r_second <= 1'b1;
                        r_out_idx <= '0;
                    end
                end
                ST_EMIT: begin
                    if (!i_stall) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'd7) begin
                            r_fill  <= '0;
                            r_total <= '0;
                            r_end   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    sha256_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (core_start),
        .i_init       (core_init),
        .i_block_word (word_in),
        .i_word_valid (word_valid),
        .o_ctl        (core_ctl),
        .i_rd_index   (r_out_idx),
        .o_rd_word    (rd_word)
    );

    assign o_data = '{digest_word: rd_word, word_index: r_out_idx,
                      last_word: (r_out_idx == 3'd7)};

endmodule
